// ===== src/fkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fkv_pkg;

  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned VALUE_FIELD_W = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CMD_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // One queued command, front to back.
  typedef struct packed {
    cmd_e                     cmd;
    logic [KEY_FIELD_W-1:0]   key;
    logic [VALUE_FIELD_W-1:0] value;
  } job_t;

endpackage

`default_nettype wire

// ===== src/fkv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/fkv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input side: takes command beats, tags the opcode and parks them in a
// two-entry queue, so a scan stalls the upstream only once it is full.
module fkv_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_valid_i,
  output logic                                   s_ready_o,
  input  wire logic [fkv_pkg::CMD_W-1:0]         s_cmd_i,
  input  wire logic [fkv_pkg::KEY_FIELD_W-1:0]   s_key_i,
  input  wire logic [fkv_pkg::VALUE_FIELD_W-1:0] s_value_i,
  output logic                                   job_valid_o,
  input  wire logic                              job_ready_i,
  output fkv_pkg::job_t                          job_o
);

  localparam int unsigned QDEPTH = 2;

  fkv_pkg::job_t slot_q [QDEPTH];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;
  fkv_pkg::job_t in_job;

  always_comb begin
    in_job.cmd   = fkv_pkg::cmd_e'(s_cmd_i);
    in_job.key   = s_key_i;
    in_job.value = s_value_i;
  end

  assign s_ready_o   = (fill_q != 2'(QDEPTH));
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o       = slot_q[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_job;
    end
  end

endmodule

`default_nettype wire

// ===== src/fkv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Execution side: walks the table one slot per cycle for insert, remove
// and find; clear needs no walk. The result sits in an output register.
module fkv_back #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              job_valid_i,
  output logic                                   job_ready_o,
  input  wire fkv_pkg::job_t                     job_i,
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output fkv_pkg::status_e                       res_status_o,
  output logic [fkv_pkg::VALUE_FIELD_W-1:0]      res_value_o,
  output logic [CNT_W-1:0]                       res_count_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned KEY_W = (KEY_BITS < fkv_pkg::KEY_FIELD_W) ?
                                  KEY_BITS : fkv_pkg::KEY_FIELD_W;
  localparam int unsigned VAL_W = (VALUE_BITS < fkv_pkg::VALUE_FIELD_W) ?
                                  VALUE_BITS : fkv_pkg::VALUE_FIELD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]             state_q, state_d;
  fkv_pkg::cmd_e          cmd_q, cmd_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [VAL_W-1:0]       val_q, val_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   issue_done_q, issue_done_d;
  logic                   chk_v_q, chk_v_d;
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic                   chk_occ_q, chk_occ_d;
  logic [ENTRIES-1:0]     occ_q, occ_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_v_q, out_v_d;
  fkv_pkg::status_e       out_st_q, out_st_d;
  logic [fkv_pkg::VALUE_FIELD_W-1:0] out_val_q, out_val_d;
  logic [CNT_W-1:0]       out_cnt_q, out_cnt_d;

  logic                   ram_we;
  logic [KEY_W-1:0]       rd_key;
  logic [VAL_W-1:0]       rd_val;
  logic                   out_free;
  logic                   hit;

  fkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (rd_key)
  );

  fkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .raddr_i (idx_q),
    .rdata_o (rd_val)
  );

  // A new command starts only with the result register free, so the
  // finishing cycle never has to wait on downstream.
  assign out_free    = !out_v_q || res_ready_i;
  assign job_ready_o = (state_q == S_IDLE) && out_free;
  assign ram_we      = (state_q == S_INS) && !occ_q[idx_q];
  assign hit         = chk_v_q && chk_occ_q && (rd_key == key_q);

  assign res_valid_o  = out_v_q;
  assign res_status_o = out_st_q;
  assign res_value_o  = out_val_q;
  assign res_count_o  = out_cnt_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    chk_v_d      = chk_v_q;
    chk_idx_d    = chk_idx_q;
    chk_occ_d    = chk_occ_q;
    occ_d        = occ_q;
    cnt_d        = cnt_q;
    out_v_d      = out_v_q && !res_ready_i;
    out_st_d     = out_st_q;
    out_val_d    = out_val_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          cmd_d        = job_i.cmd;
          key_d        = job_i.key[KEY_W-1:0];
          val_d        = job_i.value[VAL_W-1:0];
          idx_d        = '0;
          issue_done_d = 1'b0;
          chk_v_d      = 1'b0;
          case (job_i.cmd)
            fkv_pkg::CMD_INSERT: state_d = S_INS;
            fkv_pkg::CMD_REMOVE,
            fkv_pkg::CMD_FIND:   state_d = S_SRCH;
            default: begin
              occ_d     = '0;
              cnt_d     = '0;
              out_v_d   = 1'b1;
              out_st_d  = fkv_pkg::ST_OK;
              out_val_d = '0;
              out_cnt_d = '0;
            end
          endcase
        end
      end

      S_INS: begin
        out_val_d = '0;
        if (!occ_q[idx_q]) begin
          occ_d[idx_q] = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          out_v_d      = 1'b1;
          out_st_d     = fkv_pkg::ST_OK;
          out_cnt_d    = cnt_q + 1'b1;
          state_d      = S_IDLE;
        end else if (idx_q == LAST_IDX) begin
          out_v_d   = 1'b1;
          out_st_d  = fkv_pkg::ST_FULL;
          out_cnt_d = cnt_q;
          state_d   = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SRCH: begin
        // Slot idx_q is read this cycle and compared the next one.
        if (hit) begin
          out_v_d  = 1'b1;
          out_st_d = fkv_pkg::ST_OK;
          state_d  = S_IDLE;
          if (cmd_q == fkv_pkg::CMD_REMOVE) begin
            occ_d[chk_idx_q] = 1'b0;
            cnt_d            = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
            out_val_d        = '0;
            out_cnt_d        = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
          end else begin
            out_val_d = fkv_pkg::VALUE_FIELD_W'(rd_val);
            out_cnt_d = cnt_q;
          end
        end else if (chk_v_q && (chk_idx_q == LAST_IDX)) begin
          out_v_d   = 1'b1;
          out_st_d  = fkv_pkg::ST_MISSING;
          out_val_d = '0;
          out_cnt_d = cnt_q;
          state_d   = S_IDLE;
        end else begin
          chk_v_d   = !issue_done_q;
          chk_idx_d = idx_q;
          chk_occ_d = occ_q[idx_q];
          if (!issue_done_q) begin
            idx_d = idx_q + 1'b1;
            if (idx_q == LAST_IDX) begin
              issue_done_d = 1'b1;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      cnt_q        <= '0;
      out_v_q      <= 1'b0;
      chk_v_q      <= 1'b0;
      issue_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      cnt_q        <= cnt_d;
      out_v_q      <= out_v_d;
      chk_v_q      <= chk_v_d;
      issue_done_q <= issue_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    chk_occ_q <= chk_occ_d;
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
    out_cnt_q <= out_cnt_d;
  end

endmodule

`default_nettype wire

// ===== src/fixed_capacity_key_value_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key/value table of ENTRIES slots searched linearly, one result beat per
// command beat. Each command walks the slots in order through the single
// read port of the key and value memories: insert stops at the lowest free
// slot, or reports full when there is none; remove and find stop at the
// lowest matching slot, or report missing after the last slot; clear needs
// no walk.
// Up to two commands queue at the input while a walk runs. Occupancy is
// held in flops and cleared at reset, so there is no clearing pass.
module fixed_capacity_key_value_table_unit #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1),
  localparam int unsigned OUT_W     = fkv_pkg::VALUE_FIELD_W + CNT_W,
  localparam int unsigned M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [63:0]             s_axis_tdata,  // key, value
  input  wire logic [7:0]              s_axis_tuser,  // cmd, zero pad
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [M_TDATA_W-1:0]         m_axis_tdata,  // found_value, entry_count, zero pad
  output logic [7:0]                   m_axis_tuser   // status, zero pad
);

  logic                              job_valid;
  logic                              job_ready;
  fkv_pkg::job_t                     job;
  fkv_pkg::status_e                  res_status;
  logic [fkv_pkg::VALUE_FIELD_W-1:0] res_value;
  logic [CNT_W-1:0]                  res_count;

  fkv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_cmd_i     (s_axis_tuser[fkv_pkg::CMD_W-1:0]),
    .s_key_i     (s_axis_tdata[fkv_pkg::KEY_FIELD_W-1:0]),
    .s_value_i   (s_axis_tdata[63:fkv_pkg::KEY_FIELD_W]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  fkv_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .job_i        (job),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_value_o  (res_value),
    .res_count_o  (res_count)
  );

  assign m_axis_tdata = M_TDATA_W'({res_count, res_value});
  assign m_axis_tuser = 8'(res_status);

endmodule

`default_nettype wire

// ===== src/fkv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fkv_checker #(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned M_TDATA_W = 48
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [7:0]           m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned VW    = fkv_pkg::VALUE_FIELD_W;

  logic [CNT_W-1:0]                 count;
  logic [fkv_pkg::STATUS_W-1:0]     status;
  logic [VW-1:0]                    value;

  assign count  = m_axis_tdata[VW+CNT_W-1:VW];
  assign value  = m_axis_tdata[VW-1:0];
  assign status = m_axis_tuser[fkv_pkg::STATUS_W-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == fkv_pkg::ST_FULL) |-> count == CNT_W'(ENTRIES))
    else $error("full status with table not full");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == fkv_pkg::ST_MISSING) |-> value == '0)
    else $error("missing key with nonzero value");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count <= CNT_W'(ENTRIES)) &&
      (status <= fkv_pkg::STATUS_W'(fkv_pkg::ST_MISSING)) &&
      (m_axis_tuser[7:fkv_pkg::STATUS_W] == '0))
    else $error("result beat out of range");

  // Reset leaves no result beat pending.
  a_no_early: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result beat right after reset");

endmodule

bind fixed_capacity_key_value_table_unit fkv_checker #(
  .ENTRIES   (ENTRIES),
  .M_TDATA_W (M_TDATA_W)
) u_fkv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/fixed_capacity_key_value_table_unit_tb.sv =====
`timescale 1ns / 1ps

module fixed_capacity_key_value_table_unit_tb;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned KEY_POOL_N = 24;
  // Well above the longest legal quiet stretch: one full slot walk plus the
  // long reply hold-off.
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned HOLD_OFF    = 700;

  typedef struct {
    fkv_pkg::status_e status;
    logic [31:0]      found_value;
    logic [8:0]       entry_count;
  } reply_t;

  // Mirror of the table contents; predicts one reply per accepted command beat.
  class table_mirror;
    logic [31:0] key_slot [SLOTS];
    logic [31:0] val_slot [SLOTS];
    bit          used [SLOTS];
    int unsigned used_count;
    reply_t      expected_q [$];
    int unsigned fail_count;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      used_count = 0;
      fail_count = 0;
    endfunction

    // Lowest occupied slot holding the key, or -1.
    function int lookup(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i] && key_slot[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_command(fkv_pkg::cmd_e c, logic [31:0] k, logic [31:0] v);
      reply_t r;
      int     idx;
      r.status      = fkv_pkg::ST_OK;
      r.found_value = '0;
      case (c)
        fkv_pkg::CMD_INSERT: begin
          r.status = fkv_pkg::ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!used[i]) begin
              key_slot[i] = k;
              val_slot[i] = v;
              used[i]     = 1'b1;
              used_count++;
              r.status    = fkv_pkg::ST_OK;
              break;
            end
          end
        end
        fkv_pkg::CMD_REMOVE: begin
          idx = lookup(k);
          if (idx >= 0) begin
            used[idx] = 1'b0;
            used_count--;
          end else begin
            r.status = fkv_pkg::ST_MISSING;
          end
        end
        fkv_pkg::CMD_FIND: begin
          idx = lookup(k);
          if (idx >= 0) r.found_value = val_slot[idx];
          else r.status = fkv_pkg::ST_MISSING;
        end
        default: begin
          foreach (used[i]) used[i] = 1'b0;
          used_count = 0;
        end
      endcase
      r.entry_count = used_count[8:0];
      expected_q.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [31:0] fv, logic [8:0] cnt);
      reply_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: reply beat with nothing pending (status %0d value %h count %0d)",
                 $time, st, fv, cnt);
        fail_count++;
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, st);
        fail_count++;
      end
      if (fv !== e.found_value) begin
        $display("%0t: found_value expected %h got %h", $time, e.found_value, fv);
        fail_count++;
      end
      if (cnt !== e.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, e.entry_count, cnt);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // key, value
  logic [7:0]  s_axis_tuser;  // cmd, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;  // found_value, entry_count, zero pad
  logic [7:0]  m_axis_tuser;  // status, zero pad

  table_mirror sb = new();

  bit          quiet_tail;
  int unsigned hold_req;
  int unsigned stall_cycles;
  int unsigned gap_len;
  logic [31:0] key_pool [KEY_POOL_N];

  fixed_capacity_key_value_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Reply side: random back-pressure, one long hold-off on request.
  always begin
    @(negedge clk_i);
    if (hold_req > 0) begin
      m_axis_tready <= 1'b0;
      gap_len = hold_req;
      hold_req = 0;
      repeat (gap_len - 1) @(negedge clk_i);
    end else if (!quiet_tail && rst_ni && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Beat monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_reply(m_axis_tuser[1:0], m_axis_tdata[31:0], m_axis_tdata[40:32]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(fkv_pkg::cmd_e'(s_axis_tuser[1:0]), s_axis_tdata[31:0],
                        s_axis_tdata[63:32]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("fixed_capacity_key_value_table_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send_cmd(fkv_pkg::cmd_e c, logic [31:0] k, logic [31:0] v);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= {6'b0, c};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly keys from a small pool so removes and finds hit; some random misses.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned w_ins, int unsigned w_rem,
                           int unsigned w_find);
    int unsigned   r;
    fkv_pkg::cmd_e c;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) c = fkv_pkg::CMD_INSERT;
      else if (r < w_ins + w_rem) c = fkv_pkg::CMD_REMOVE;
      else if (r < w_ins + w_rem + w_find) c = fkv_pkg::CMD_FIND;
      else c = fkv_pkg::CMD_CLEAR;
      send_cmd(c, pick_key(), $urandom);
    end
  endtask

  initial begin
    logic [31:0] rk;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    quiet_tail    = 1'b0;
    hold_req      = 0;
    stall_cycles  = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, misses, holes, clear.
    send_cmd(fkv_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(fkv_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5678);  // duplicate key
    send_cmd(fkv_pkg::CMD_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(fkv_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_FIND,   32'h0000_0000, 32'h0000_0000);  // second copy now
    send_cmd(fkv_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000);  // miss
    send_cmd(fkv_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);  // miss
    send_cmd(fkv_pkg::CMD_INSERT, 32'h0000_0001, 32'hA5A5_A5A5);
    send_cmd(fkv_pkg::CMD_INSERT, 32'h0000_0002, 32'h5A5A_5A5A);
    send_cmd(fkv_pkg::CMD_REMOVE, 32'h0000_0001, 32'h0000_0000);  // leaves a hole
    send_cmd(fkv_pkg::CMD_INSERT, 32'h0000_0003, 32'hDEAD_BEEF);  // refills the hole
    send_cmd(fkv_pkg::CMD_FIND,   32'h0000_0003, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_FIND,   32'h0000_0002, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(fkv_pkg::CMD_FIND,   32'h0000_0002, 32'h0000_0000);  // gone after clear
    send_cmd(fkv_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_cmd(fkv_pkg::CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);  // clear when empty
    rk = $urandom;
    send_cmd(fkv_pkg::CMD_INSERT, rk, $urandom);
    send_cmd(fkv_pkg::CMD_FIND,   rk, 32'h0000_0000);
    wait_drained();

    run_phase(300, 40, 25, 33);

    // Long reply hold-off while commands keep coming, then fill past capacity.
    hold_req = HOLD_OFF;
    run_phase(420, 75, 5, 20);
    wait_drained();

    run_phase(420, 15, 50, 35);
    wait_drained();

    quiet_tail = 1'b1;
    run_phase(500, 40, 25, 32);
    wait_drained();

    repeat (SLOTS + 20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("fixed_capacity_key_value_table_unit verification clean");
    end else begin
      $display("fixed_capacity_key_value_table_unit verification failed");
    end
    $finish;
  end

endmodule
